>>> rtl/core/fds_pkg.sv
// Shared types and constants for the FAT long-name directory scanner.
// Used by every module under rtl/core; depends on nothing else.
package fds_pkg;

  localparam int NAME_CAP = 130;
  localparam int NS_AW = $clog2(NAME_CAP);
  localparam int NS_IW = $clog2(NAME_CAP + 1);
  localparam int EB_AW = 5;

  localparam int LONG_CHARS = 13;
  localparam int SHORT_LEN = 11;
  localparam int EXT_POS = 8;
  localparam int CHUNK_CHARS = 8;

  localparam logic [EB_AW-1:0] POS_ATTR = 5'd11;
  localparam logic [EB_AW-1:0] POS_CHK = 5'd13;
  localparam logic [EB_AW-1:0] POS_LAST = 5'd31;

  localparam logic [5:0] ATTR_LFN = 6'h0F;
  localparam logic [2:0] LFN_LAST_HI = 3'b010;
  localparam logic [7:0] B_DELETED = 8'hE5;
  localparam logic [7:0] B_DOT = 8'h2E;
  localparam logic [7:0] B_SPACE = 8'h20;
  localparam logic [7:0] B_NUL = 8'h00;

  // Byte offsets of the low bytes of the 13 UTF-16 characters in a long entry.
  localparam logic [EB_AW-1:0] CHAR_OFFS [LONG_CHARS] = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
  };

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_END   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] entry_byte;
  } entry_req_t;

  typedef struct packed {
    logic        found;
    logic        long_form;
    logic [63:0] name_chars;
    logic [3:0]  char_count;
    logic        last;
  } name_rsp_t;

  // Entry header fields captured while the bytes stream in.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] attr;
    logic [7:0] chk;
    logic [7:0] sum;
  } hdr_t;

  // One character request from the sequencer to the chunk assembler.
  typedef struct packed {
    logic       push;
    logic       end_mark;
    logic       not_found;
    logic       long_form;
    logic [7:0] chr;
  } chr_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_COPY,
    ST_EMIT,
    ST_NOTFOUND
  } state_t;

endpackage

>>> rtl/core/fat_long_name_directory_scanner.sv
// FAT long-name directory scanner: one directory byte per cycle while idle; after the
// 32nd byte of an entry input stalls for the decode state, then while a long entry's
// characters are copied into the name store, or while the name characters are read
// and emitted, including any stalls on the output.
// Reset is synchronous and clears control state; the memories are not cleared.
// Depends on fds_pkg, fds_entry, fds_names and fds_chunk.
module fat_long_name_directory_scanner import fds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       entry_valid,
  output logic       entry_ready,
  input  entry_req_t entry_data,
  output logic       name_valid,
  input  logic       name_ready,
  output name_rsp_t  name_data,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  localparam logic REG_HIDE = 1'b0;

  state_t state, state_next;

  logic [EB_AW-1:0] pos;
  logic             pending;
  logic [4:0]       expected;
  logic [7:0]       long_chk;
  logic [NS_IW-1:0] fill;
  logic             scan_ended;
  logic             hide;

  logic [3:0] copy_k, copy_kd;
  logic       copy_v;

  logic [NS_IW-1:0] src_idx;
  logic             src_on, d_valid, d_end, dot_done, mode_long;
  logic [3:0]       d_idx;

  logic             accept;
  hdr_t             hdr;
  logic             e_wr_en, e_rd_en, n_wr_en, n_rd_en;
  logic [EB_AW-1:0] e_rd_addr;
  logic [NS_AW-1:0] n_wr_addr;
  logic [7:0]       e_rd_data, n_rd_data, data;

  logic             is_long, first_ok, seq_ok, lfn_take, can_store, short_ok, use_long;
  logic [NS_IW-1:0] fill_src;

  logic     is_skip, is_dot, is_endc, take, done, pop, adv, issue, end_next;
  chr_req_t req;

  assign entry_ready = (state == ST_IDLE);
  assign accept = entry_valid && entry_ready;
  assign e_wr_en = accept && (entry_data.command == CMD_BYTE) && !scan_ended;

  // Entry decode, from the captured header fields and the long-name sequence state.
  assign is_long = (hdr.attr[5:0] == ATTR_LFN);
  assign first_ok = (hdr.b0[7:5] == LFN_LAST_HI);
  assign seq_ok = (expected != 5'd0) && (hdr.b0 == {3'b000, 5'(expected - 5'd1)}) &&
                  (hdr.chk == long_chk);
  assign lfn_take = pending ? seq_ok : first_ok;
  assign fill_src = pending ? fill : NS_IW'(NAME_CAP);
  assign can_store = (fill_src >= NS_IW'(LONG_CHARS));
  assign short_ok = !hdr.attr[3] && (hdr.b0 != B_DELETED) && (hdr.b0 != B_NUL) &&
                    !(hide && (hdr.b0 == B_DOT));
  assign use_long = pending && (hdr.sum == long_chk) && (expected == 5'd1);

  // Character stream for emission: the data stage classifies the byte read.
  assign data = mode_long ? n_rd_data : e_rd_data;
  assign is_skip = !mode_long && !d_end && (data == B_SPACE);
  assign is_dot = !mode_long && !d_end && !is_skip && (d_idx == 4'(EXT_POS)) && !dot_done;
  assign is_endc = d_end || (data == B_NUL);
  assign end_next = mode_long ? (src_idx == NS_IW'(NAME_CAP)) : (src_idx == NS_IW'(SHORT_LEN));

  always_comb begin
    state_next = state;
    req = '0;
    req.long_form = mode_long;
    done = 1'b0;
    pop = 1'b0;
    adv = 1'b0;
    issue = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && !scan_ended) begin
          if (entry_data.command == CMD_BYTE && pos == POS_LAST) begin
            state_next = ST_DECIDE;
          end else if (entry_data.command == CMD_END) begin
            state_next = ST_NOTFOUND;
          end
        end
      end
      ST_DECIDE: begin
        if (is_long) begin
          state_next = (lfn_take && can_store) ? ST_COPY : ST_IDLE;
        end else if (short_ok) begin
          state_next = ST_EMIT;
        end else if (hdr.b0 == B_NUL) begin
          state_next = ST_NOTFOUND;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_COPY: begin
        if (copy_k == 4'(LONG_CHARS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        req.push = d_valid && !is_skip;
        if (is_dot) begin
          req.chr = B_DOT;
        end else if (is_endc) begin
          req.end_mark = 1'b1;
        end else begin
          req.chr = data;
        end
        done = take && req.end_mark;
        pop = d_valid && (is_skip || (take && !is_dot));
        adv = !d_valid || pop;
        issue = src_on && adv && !done;
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      ST_NOTFOUND: begin
        req.push = 1'b1;
        req.not_found = 1'b1;
        req.long_form = 1'b0;
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign e_rd_en = (state == ST_COPY) || (issue && !mode_long && !end_next);
  assign e_rd_addr = (state == ST_COPY) ? CHAR_OFFS[copy_k] : {1'b0, src_idx[3:0]};
  assign n_rd_en = issue && mode_long && !end_next;
  assign n_wr_en = copy_v;
  assign n_wr_addr = NS_AW'(fill + NS_IW'(copy_kd));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    copy_kd <= copy_k;
    if (rst) begin
      pos <= '0;
      pending <= 1'b0;
      expected <= '0;
      long_chk <= '0;
      fill <= NS_IW'(NAME_CAP);
      scan_ended <= 1'b0;
      hide <= 1'b0;
      copy_k <= '0;
      copy_v <= 1'b0;
      src_idx <= '0;
      src_on <= 1'b0;
      d_valid <= 1'b0;
      d_end <= 1'b0;
      d_idx <= '0;
      dot_done <= 1'b0;
      mode_long <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_HIDE) begin
        hide <= pwdata[0];
      end
      copy_v <= (state == ST_COPY);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (entry_data.command)
              CMD_START: begin
                pos <= '0;
                pending <= 1'b0;
                expected <= '0;
                long_chk <= '0;
                fill <= NS_IW'(NAME_CAP);
                scan_ended <= 1'b0;
              end
              CMD_BYTE: begin
                if (!scan_ended) begin
                  pos <= EB_AW'(pos + 1'b1);
                end
              end
              CMD_END: begin
                if (!scan_ended) begin
                  scan_ended <= 1'b1;
                  pending <= 1'b0;
                  pos <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_DECIDE: begin
          if (is_long) begin
            if (lfn_take) begin
              if (!pending) begin
                expected <= hdr.b0[4:0];
                long_chk <= hdr.chk;
                pending <= 1'b1;
              end else begin
                expected <= 5'(expected - 5'd1);
              end
              if (can_store) begin
                fill <= NS_IW'(fill_src - NS_IW'(LONG_CHARS));
              end
              copy_k <= '0;
            end else begin
              pending <= 1'b0;
            end
          end else if (short_ok) begin
            pending <= 1'b0;
            mode_long <= use_long;
            src_idx <= use_long ? fill : '0;
            src_on <= 1'b1;
            dot_done <= 1'b0;
            d_valid <= 1'b0;
          end else if (hdr.b0 == B_NUL) begin
            scan_ended <= 1'b1;
            pending <= 1'b0;
            pos <= '0;
          end else begin
            pending <= 1'b0;
          end
        end
        ST_COPY: begin
          copy_k <= 4'(copy_k + 4'd1);
        end
        ST_EMIT: begin
          if (done) begin
            src_on <= 1'b0;
            d_valid <= 1'b0;
          end else if (issue) begin
            d_valid <= 1'b1;
            d_end <= end_next;
            d_idx <= src_idx[3:0];
            src_idx <= NS_IW'(src_idx + 1'b1);
            if (end_next) begin
              src_on <= 1'b0;
            end
          end else if (pop) begin
            d_valid <= 1'b0;
          end
          if (take && is_dot) begin
            dot_done <= 1'b1;
          end
        end
        ST_NOTFOUND: begin
          scan_ended <= 1'b1;
          pending <= 1'b0;
          pos <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HIDE: prdata = {31'b0, hide};
      default:  prdata = 32'b0;
    endcase
  end
  assign pready = 1'b1;

  fds_entry u_entry (
    .clk     (clk),
    .wr_en   (e_wr_en),
    .wr_pos  (pos),
    .wr_byte (entry_data.entry_byte),
    .rd_en   (e_rd_en),
    .rd_addr (e_rd_addr),
    .rd_data (e_rd_data),
    .hdr     (hdr)
  );

  fds_names u_names (
    .clk     (clk),
    .wr_en   (n_wr_en),
    .wr_addr (n_wr_addr),
    .wr_data (e_rd_data),
    .rd_en   (n_rd_en),
    .rd_addr (src_idx[NS_AW-1:0]),
    .rd_data (n_rd_data)
  );

  fds_chunk u_chunk (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .take       (take),
    .name_valid (name_valid),
    .name_ready (name_ready),
    .name_data  (name_data)
  );

endmodule

>>> rtl/core/fds_entry.sv
// Entry buffer: 32-byte memory holding the current directory entry, plus
// header capture and the running short-name checksum. Depends on fds_pkg.
module fds_entry import fds_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [EB_AW-1:0] wr_pos,
  input  logic [7:0]       wr_byte,
  input  logic             rd_en,
  input  logic [EB_AW-1:0] rd_addr,
  output logic [7:0]       rd_data,
  output hdr_t             hdr
);

  logic [7:0] mem [2**EB_AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_pos] <= wr_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // The checksum rotates right and adds each of the 11 short-name bytes.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_pos == '0) begin
        hdr.b0 <= wr_byte;
        hdr.sum <= wr_byte;
      end else if (wr_pos < EB_AW'(SHORT_LEN)) begin
        hdr.sum <= 8'({hdr.sum[0], hdr.sum[7:1]} + wr_byte);
      end
      if (wr_pos == POS_ATTR) begin
        hdr.attr <= wr_byte;
      end
      if (wr_pos == POS_CHK) begin
        hdr.chk <= wr_byte;
      end
    end
  end

endmodule

>>> rtl/core/fds_names.sv
// Name store: memory of long-name characters, filled back to front.
// One write port and one registered read port. Depends on fds_pkg.
module fds_names import fds_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [NS_AW-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [NS_AW-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [NAME_CAP];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/fds_chunk.sv
// Chunk assembler: packs characters into 8-character results and holds
// them in the output register of the name channel. Depends on fds_pkg.
module fds_chunk import fds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  chr_req_t  req,
  output logic      take,
  output logic      name_valid,
  input  logic      name_ready,
  output name_rsp_t name_data
);

  logic [63:0] held;
  logic [3:0]  count;
  logic        out_free;
  logic        need_out;
  logic        full;

  assign full = (count == 4'(CHUNK_CHARS));
  assign out_free = !name_valid || name_ready;
  // A full chunk is only sent once the next character shows it is not the last.
  assign need_out = req.end_mark || req.not_found || full;
  assign take = req.push && (!need_out || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      name_valid <= 1'b0;
      held <= '0;
      count <= '0;
    end else begin
      if (name_valid && name_ready) begin
        name_valid <= 1'b0;
      end
      if (take) begin
        if (req.not_found) begin
          name_valid <= 1'b1;
          name_data <= '{found: 1'b0, long_form: 1'b0, name_chars: '0,
                         char_count: '0, last: 1'b1};
          held <= '0;
          count <= '0;
        end else if (req.end_mark) begin
          name_valid <= 1'b1;
          name_data <= '{found: 1'b1, long_form: req.long_form, name_chars: held,
                         char_count: count, last: 1'b1};
          held <= '0;
          count <= '0;
        end else if (full) begin
          name_valid <= 1'b1;
          name_data <= '{found: 1'b1, long_form: req.long_form, name_chars: held,
                         char_count: count, last: 1'b0};
          held <= {56'b0, req.chr};
          count <= 4'd1;
        end else begin
          held <= held | ({56'b0, req.chr} << {count[2:0], 3'b000});
          count <= 4'(count + 4'd1);
        end
      end
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the FAT long-name directory scanner: directed and random
// directory streams go in, a predictor of the name chunks feeds an in-order scoreboard.
// Depends on fds_pkg and fat_long_name_directory_scanner.
module tb_top;
  import fds_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_LFN_ENT = 12;
  localparam int LFN_TEXT = 13 * MAX_LFN_ENT;
  localparam int RAND_ITEMS = 410;
  localparam int RAND_NAMES = 48;
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [2:0] REG_HIDE_DOTS = 3'd0;
  localparam int LFN_AT [13] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};
  localparam logic [5:0] LFN_ATTR = 6'h0F;
  localparam logic [7:0] LAST_MARK = 8'h40;
  localparam logic [7:0] DELETED_MARK = 8'hE5;
  localparam logic [7:0] DOT = 8'h2E;
  localparam logic [7:0] SPACE = 8'h20;
  localparam logic [7:0] ATTR_VOLUME = 8'h08;
  localparam logic [7:0] ATTR_DIR = 8'h10;
  localparam logic [7:0] ATTR_ARCHIVE = 8'h20;

  typedef enum int {
    FLAW_NONE, FLAW_SUM_BYTE, FLAW_ORDINAL, FLAW_GAP, FLAW_STRAY, FLAW_SHORT
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        entry_valid = 1'b0;
  logic        entry_ready;
  entry_req_t  entry_data = '0;
  logic        name_valid;
  logic        name_ready = 1'b0;
  name_rsp_t   name_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fat_long_name_directory_scanner dut (
    .clk(clk), .rst(rst),
    .entry_valid(entry_valid), .entry_ready(entry_ready), .entry_data(entry_data),
    .name_valid(name_valid), .name_ready(name_ready), .name_data(name_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Predictor state, a copy of what the scanner keeps.
  logic       hide_dot;
  logic [4:0] pos_q;
  logic [7:0] ebuf [32];
  logic       lfn_open;
  logic [4:0] next_ord;
  logic [7:0] lfn_sum;
  int         fill_at;
  logic [7:0] nstore [NAME_CAP + 1];
  logic       scan_done;
  logic [7:0] name_buf [NAME_CAP + 1];

  name_rsp_t  expected_names [$];
  int         live_items = 0;
  int         names_due = 0;
  int         mismatches = 0;

  // Stimulus scratch: the entry being sent, the short name and the long-name text.
  logic [7:0]        dir_ent [32];
  logic [0:10][7:0]  sfn;
  logic [7:0]        sfn_attr;
  logic [7:0]        lfn_lo [LFN_TEXT];
  logic [7:0]        lfn_hi [LFN_TEXT];
  bit                gaps_on = 1'b1;
  bit                stalls_on = 1'b1;
  int                hold_cycles = 0;

  function automatic logic [7:0] short_name_sum(input logic [0:10][7:0] nm);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 11; i++) acc = {acc[0], acc[7:1]} + nm[i];
    return acc;
  endfunction

  function automatic void clear_scan_model();
    pos_q = '0;
    lfn_open = 1'b0;
    next_ord = '0;
    lfn_sum = '0;
    fill_at = NAME_CAP;
    scan_done = 1'b0;
    for (int i = 0; i < 32; i++) ebuf[i] = '0;
    for (int i = 0; i <= NAME_CAP; i++) nstore[i] = '0;
  endfunction

  // Splits name_buf[0..len-1] into chunks of up to eight characters.
  function automatic void queue_chunks(input int len, input logic longf);
    name_rsp_t r;
    int p;
    int n;
    p = 0;
    do begin
      n = len - p;
      if (n > 8) n = 8;
      r = '0;
      r.found = 1'b1;
      r.long_form = longf;
      for (int i = 0; i < n; i++) r.name_chars[8*i +: 8] = name_buf[p + i];
      p += n;
      r.char_count = 4'(n);
      r.last = (p >= len);
      expected_names.push_back(r);
      names_due++;
    end while (p < len);
  endfunction

  function automatic void queue_not_found();
    name_rsp_t r;
    scan_done = 1'b1;
    lfn_open = 1'b0;
    pos_q = '0;
    r = '0;
    r.last = 1'b1;
    expected_names.push_back(r);
    names_due++;
  endfunction

  function automatic void decode_entry();
    logic [7:0] b0;
    logic [7:0] attr;
    logic [7:0] c;
    logic [0:10][7:0] nm;
    int len;
    int n;
    b0 = ebuf[0];
    attr = ebuf[11];
    if (attr[5:0] == LFN_ATTR) begin
      if (!lfn_open) begin
        if ((b0 & 8'hE0) != LAST_MARK) return;
        next_ord = b0[4:0];
        lfn_sum = ebuf[13];
        lfn_open = 1'b1;
        fill_at = NAME_CAP;
        nstore[NAME_CAP] = '0;
      end else begin
        if (next_ord == 0 || b0 != {3'b000, next_ord - 5'd1} || ebuf[13] != lfn_sum) begin
          lfn_open = 1'b0;
          return;
        end
        next_ord = next_ord - 5'd1;
      end
      // Entries past the tenth find no room and are only checked.
      if (fill_at >= 13) begin
        fill_at -= 13;
        for (int i = 0; i < 13; i++) nstore[fill_at + i] = ebuf[LFN_AT[i]];
      end
      return;
    end
    if (!attr[3] && b0 != DELETED_MARK && b0 != 8'h00 && !(hide_dot && b0 == DOT)) begin
      if (lfn_open) begin
        for (int i = 0; i < 11; i++) nm[i] = ebuf[i];
        if (short_name_sum(nm) != lfn_sum || next_ord != 5'd1) lfn_open = 1'b0;
      end
      if (lfn_open) begin
        lfn_open = 1'b0;
        len = 0;
        while (fill_at + len < NAME_CAP && nstore[fill_at + len] != 8'h00) len++;
        for (int i = 0; i < len; i++) name_buf[i] = nstore[fill_at + i];
        queue_chunks(len, 1'b1);
      end else begin
        len = 0;
        for (int i = 0; i < 11; i++) begin
          c = ebuf[i];
          if (c != SPACE) begin
            if (i == 8) begin
              name_buf[len] = DOT;
              len++;
            end
            name_buf[len] = c;
            len++;
          end
        end
        n = 0;
        while (n < len && name_buf[n] != 8'h00) n++;
        queue_chunks(n, 1'b0);
      end
      return;
    end
    if (b0 == 8'h00) begin
      queue_not_found();
      return;
    end
    lfn_open = 1'b0;
  endfunction

  function automatic void model_request(input entry_req_t r);
    case (r.command)
      CMD_START: begin
        clear_scan_model();
        live_items++;
      end
      CMD_BYTE: begin
        if (!scan_done) begin
          live_items++;
          ebuf[pos_q] = r.entry_byte;
          pos_q = pos_q + 5'd1;
          if (pos_q == 5'd0) decode_entry();
        end
      end
      CMD_END: begin
        if (!scan_done) begin
          live_items++;
          queue_not_found();
        end
      end
      default: ;
    endcase
  endfunction

  // Offers one request and returns at the edge that accepts it.
  task automatic send_req(input cmd_t cmd, input logic [7:0] b);
    entry_req_t r;
    int gap;
    r.command = cmd;
    r.entry_byte = b;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      entry_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    entry_valid <= 1'b1;
    entry_data <= r;
    do @(posedge clk); while (!entry_ready);
    model_request(r);
  endtask

  task automatic send_entry();
    for (int i = 0; i < 32; i++) send_req(CMD_BYTE, dir_ent[i]);
  endtask

  task automatic put_short();
    for (int i = 0; i < 32; i++) dir_ent[i] = 8'($urandom);
    for (int i = 0; i < 11; i++) dir_ent[i] = sfn[i];
    dir_ent[11] = sfn_attr;
    send_entry();
  endtask

  task automatic name_short(input string s, input logic [7:0] attr);
    for (int i = 0; i < 11; i++) sfn[i] = (i < s.len()) ? s[i] : SPACE;
    sfn_attr = attr;
  endtask

  task automatic random_short();
    int pick;
    sfn[0] = 8'($urandom_range(65, 90));
    if ($urandom_range(0, 7) == 0) sfn[0] = 8'($urandom_range(1, 255));
    if (sfn[0] == DELETED_MARK) sfn[0] = 8'h58;
    for (int i = 1; i < 11; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) sfn[i] = 8'($urandom_range(48, 90));
      else if (pick < 8) sfn[i] = SPACE;
      else sfn[i] = 8'($urandom);
    end
    sfn_attr = 8'($urandom) & 8'hF7;
  endtask

  // Text for n entries: characters, one NUL, then 0xFFFF padding.
  task automatic text_long(input string s, input int n_ent);
    for (int j = 0; j < 13 * n_ent; j++) begin
      if (j < s.len()) begin
        lfn_lo[j] = s[j];
        lfn_hi[j] = 8'h00;
      end else begin
        lfn_lo[j] = (j == s.len()) ? 8'h00 : 8'hFF;
        lfn_hi[j] = lfn_lo[j];
      end
    end
  endtask

  task automatic random_long_text(input int n_ent, input int len);
    for (int j = 0; j < 13 * n_ent; j++) begin
      if (j < len) begin
        lfn_lo[j] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                                 : 8'($urandom_range(33, 126));
        lfn_hi[j] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
      end else begin
        lfn_lo[j] = (j == len) ? 8'h00 : 8'hFF;
        lfn_hi[j] = lfn_lo[j];
      end
    end
  endtask

  // Sends the long entry that carries characters of the given part (1 is the first).
  task automatic send_lfn_part(input logic [7:0] ordb, input logic [7:0] chk, input int part);
    int base;
    base = (part - 1) * 13;
    for (int i = 0; i < 32; i++) dir_ent[i] = 8'($urandom);
    dir_ent[0] = ordb;
    dir_ent[11] = {2'($urandom), LFN_ATTR};
    dir_ent[12] = 8'h00;
    dir_ent[13] = chk;
    dir_ent[26] = 8'h00;
    dir_ent[27] = 8'h00;
    for (int j = 0; j < 13; j++) begin
      dir_ent[LFN_AT[j]] = lfn_lo[base + j];
      dir_ent[LFN_AT[j] + 1] = lfn_hi[base + j];
    end
    send_entry();
  endtask

  task automatic send_stray(input bit volume);
    for (int i = 0; i < 32; i++) dir_ent[i] = 8'($urandom);
    if (volume) begin
      dir_ent[0] = 8'($urandom_range(65, 90));
      dir_ent[11] = ATTR_VOLUME;
    end else begin
      dir_ent[0] = DELETED_MARK;
      dir_ent[11] = 8'($urandom) & 8'hF7;
    end
    send_entry();
  endtask

  // A long-name sequence followed by its short entry, optionally with one flaw.
  task automatic send_long_name(input int n_ent, input flaw_t flaw);
    logic [7:0] chk;
    logic [7:0] ordb;
    logic [7:0] c;
    int bad;
    chk = short_name_sum(sfn);
    bad = $urandom_range(1, n_ent);
    for (int k = n_ent; k >= 1; k--) begin
      ordb = 8'(k) | ((k == n_ent) ? LAST_MARK : 8'h00);
      c = chk;
      if (k == bad) begin
        case (flaw)
          FLAW_SUM_BYTE: c = chk ^ (8'h01 << $urandom_range(0, 7));
          FLAW_ORDINAL:  ordb = ordb ^ (8'h01 << $urandom_range(0, 4));
          FLAW_STRAY:    send_stray($urandom_range(0, 1));
          default: ;
        endcase
      end
      if (!(flaw == FLAW_GAP && k == bad && k != n_ent)) send_lfn_part(ordb, c, k);
    end
    if (flaw == FLAW_SHORT) sfn[$urandom_range(1, 10)] ^= 8'h01 << $urandom_range(0, 7);
    put_short();
  endtask

  task automatic send_free_entry();
    for (int i = 0; i < 32; i++) dir_ent[i] = 8'($urandom);
    dir_ent[0] = 8'h00;
    dir_ent[11] = 8'($urandom) & 8'hF7;
    send_entry();
  endtask

  task automatic send_garbage();
    for (int i = 0; i < 32; i++) dir_ent[i] = 8'($urandom);
    send_entry();
  endtask

  // Waits until the scanner has delivered everything and gone quiet.
  task automatic settle_block();
    entry_valid <= 1'b0;
    while (expected_names.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_hide_dots(input logic v);
    settle_block();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_HIDE_DOTS;
    pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    hide_dot = v;
    @(posedge clk);
  endtask

  task automatic check_name(input name_rsp_t got);
    name_rsp_t want;
    if (expected_names.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: unexpected name chunk found=%0d long=%0d chars=%h count=%0d last=%0d",
                 $realtime, got.found, got.long_form, got.name_chars, got.char_count, got.last);
      return;
    end
    want = expected_names.pop_front();
    if (got.found !== want.found || got.long_form !== want.long_form ||
        got.name_chars !== want.name_chars || got.char_count !== want.char_count ||
        got.last !== want.last) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: name chunk mismatch: expected found=%0d long=%0d chars=%h count=%0d last=%0d, got found=%0d long=%0d chars=%h count=%0d last=%0d",
                 $realtime, want.found, want.long_form, want.name_chars, want.char_count,
                 want.last, got.found, got.long_form, got.name_chars, got.char_count,
                 got.last);
    end
  endtask

  task automatic test_scan_commands();
    send_req(CMD_START, 8'hFF);
    send_req(CMD_END, 8'h00);
    send_req(CMD_END, 8'hFF);
    send_req(CMD_NONE, 8'hA5);
    send_req(CMD_BYTE, 8'h5A);
    send_req(CMD_START, 8'h00);
    send_req(CMD_NONE, 8'hFF);
    repeat (5) send_req(CMD_BYTE, 8'($urandom));
    // The partial entry is dropped by the end of the directory.
    send_req(CMD_END, 8'h00);
    send_req(CMD_START, 8'h00);
    name_short("AFTER   END", ATTR_ARCHIVE);
    put_short();
    send_req(CMD_END, 8'h00);
  endtask

  task automatic test_short_entries();
    send_req(CMD_START, 8'h00);
    name_short("README  TXT", ATTR_ARCHIVE);
    put_short();
    name_short("A", 8'h00);
    put_short();
    name_short("NOEXT     C", 8'h01);
    put_short();
    name_short("ABXDEFGHTXT", ATTR_ARCHIVE);
    sfn[2] = 8'h00;
    put_short();
    for (int i = 0; i < 11; i++) sfn[i] = 8'hFF;
    sfn_attr = 8'hF7;
    put_short();
    name_short(".", ATTR_DIR);
    put_short();
    name_short("..", ATTR_DIR);
    put_short();
    send_stray(1'b0);
    send_stray(1'b1);
    send_free_entry();
    send_garbage();
    send_req(CMD_START, 8'h00);
    name_short("LAST    BIN", 8'h00);
    put_short();
    send_req(CMD_END, 8'h00);
  endtask

  task automatic test_long_sequences();
    logic [7:0] chk;
    send_req(CMD_START, 8'h00);
    text_long("LongFileName.txt", 2);
    name_short("LONGFI~1TXT", ATTR_ARCHIVE);
    send_long_name(2, FLAW_NONE);
    text_long("", 1);
    name_short("EMPTY   DAT", 8'h00);
    send_long_name(1, FLAW_NONE);
    text_long("ThirteenChars", 1);
    name_short("THIRTE~1", ATTR_DIR);
    send_long_name(1, FLAW_NONE);
    text_long("A broken sequence of entries", 3);
    name_short("ABROKE~1TXT", ATTR_ARCHIVE);
    send_long_name(3, FLAW_SUM_BYTE);
    send_long_name(3, FLAW_ORDINAL);
    send_long_name(3, FLAW_GAP);
    send_long_name(3, FLAW_STRAY);
    send_long_name(3, FLAW_SHORT);
    // A last entry with ordinal zero is broken by whatever long entry follows.
    name_short("ZEROORD TXT", ATTR_ARCHIVE);
    chk = short_name_sum(sfn);
    send_lfn_part(LAST_MARK, chk, 1);
    send_lfn_part(8'h00, chk, 1);
    put_short();
    // Ordinal 31 never counts down to one before the short entry.
    send_lfn_part(LAST_MARK | 8'h1F, chk, 1);
    put_short();
    // Long entries without the last mark cannot open a sequence.
    send_lfn_part(8'h00, chk, 1);
    send_lfn_part(8'h01, chk, 1);
    send_lfn_part(8'hC1, chk, 1);
    put_short();
    send_free_entry();
  endtask

  task automatic test_hide_dot_names();
    write_hide_dots(1'b1);
    send_req(CMD_START, 8'h00);
    name_short(".", ATTR_DIR);
    put_short();
    name_short("..", ATTR_DIR);
    put_short();
    text_long("dotfile", 1);
    name_short(".PROFILE", ATTR_ARCHIVE);
    send_long_name(1, FLAW_NONE);
    name_short("VISIBLE TXT", ATTR_ARCHIVE);
    put_short();
    send_req(CMD_END, 8'h00);
    write_hide_dots(1'b0);
    send_req(CMD_START, 8'h00);
    name_short(".", ATTR_DIR);
    put_short();
    name_short(".PROFILE", ATTR_ARCHIVE);
    send_long_name(1, FLAW_NONE);
    send_req(CMD_END, 8'h00);
  endtask

  // The name sink holds off long enough for the scanner to back up onto its input.
  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    send_req(CMD_START, 8'h00);
    hold_cycles = HOLD_OFF_CYCLES;
    random_long_text(MAX_LFN_ENT, LFN_TEXT);
    random_short();
    send_long_name(MAX_LFN_ENT, FLAW_NONE);
    repeat (4) begin
      random_short();
      put_short();
    end
    send_req(CMD_END, 8'h00);
    gaps_on = 1'b1;
  endtask

  task automatic random_scan();
    int pick;
    int n_ent;
    bit cut;
    cut = 1'b0;
    send_req(CMD_START, 8'($urandom));
    repeat ($urandom_range(1, 4)) begin
      if (!cut) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          n_ent = ($urandom_range(0, 9) == 0) ? $urandom_range(4, MAX_LFN_ENT)
                                              : $urandom_range(1, 3);
          random_long_text(n_ent, $urandom_range(0, 13 * n_ent));
          random_short();
          send_long_name(n_ent, (pick < 40) ? FLAW_NONE : flaw_t'($urandom_range(1, 5)));
        end else if (pick < 75) begin
          random_short();
          put_short();
        end else if (pick < 83) begin
          send_stray($urandom_range(0, 1));
        end else if (pick < 88) begin
          name_short($urandom_range(0, 1) ? "." : "..", ATTR_DIR);
          put_short();
        end else if (pick < 95) begin
          send_garbage();
        end else begin
          repeat ($urandom_range(1, 31)) send_req(CMD_BYTE, 8'($urandom));
          cut = 1'b1;
        end
      end
    end
    pick = $urandom_range(0, 99);
    if (cut || pick < 50) send_req(CMD_END, 8'($urandom));
    else if (pick < 80) send_free_entry();
    if ($urandom_range(0, 3) == 0) begin
      send_req(CMD_NONE, 8'($urandom));
      send_req(CMD_BYTE, 8'($urandom));
      send_req(CMD_END, 8'($urandom));
    end
  endtask

  task automatic test_random_directory();
    int items0;
    int names0;
    int phase;
    items0 = live_items;
    names0 = names_due;
    phase = 0;
    while (live_items - items0 < RAND_ITEMS || names_due - names0 < RAND_NAMES) begin
      write_hide_dots((phase % 4 == 1) ? 1'b1 : 1'($urandom_range(0, 1)));
      gaps_on = (phase % 3) != 2;
      stalls_on = (phase % 4) != 3;
      repeat (2) random_scan();
      phase++;
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin : name_sink
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = stalls_on ? $urandom_range(0, 16) : 0;
      stall += hold_cycles;
      hold_cycles = 0;
      if (stall > 0) begin
        name_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      name_ready <= 1'b1;
      do @(posedge clk); while (!name_valid);
      check_name(name_data);
    end
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    hide_dot = 1'b0;
    clear_scan_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_hide_dots(1'b0);
    test_scan_commands();
    test_short_entries();
    test_long_sequences();
    test_hide_dot_names();
    test_output_backpressure();
    test_random_directory();
    settle_block();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
